FILE: rtl/ray_box_slab_intersect_macros.svh
// assertion macros for the ray box block
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

`define RBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/rbs_pkg.sv
package rbs_pkg;

    localparam int AXES      = 3;
    localparam int DIR_FRAC  = 14;
    localparam int QBITS     = 47;

    localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] T_MIN = 32'sh80000000;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    // one slab division in flight
    typedef struct packed {
        logic [QBITS-1:0] rem;
        logic [QBITS-1:0] quo;
        logic [15:0]      div;
        logic             neg;
    } t_div;

    // per axis bookkeeping carried along the divider
    typedef struct packed {
        logic zero;
        logic in_slab;
    } t_axis;

    function automatic logic signed [31:0] sat32(input logic signed [QBITS:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(QBITS-31){1'b0}}, T_MAX})) begin
            r = T_MAX;
        end else if (v < $signed({{(QBITS-31){1'b1}}, T_MIN})) begin
            r = T_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/rbs_div_pipe.sv
module rbs_div_pipe
    import rbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [32:0]      i_num,
    input  logic signed [15:0]      i_den,
    output logic signed [31:0]      o_t
);

    t_div r_st [QBITS+1];
    logic signed [QBITS:0] w_q;

    always_ff @(posedge i_clk) begin
        logic [QBITS-1:0] an;
        logic [15:0]      ad;
        an = i_num[32] ? QBITS'(-({{(QBITS-33){i_num[32]}}, i_num}) <<< DIR_FRAC)
                       : QBITS'({{(QBITS-33){1'b0}}, i_num} << DIR_FRAC);
        ad = i_den[15] ? 16'(-i_den) : i_den;
        r_st[0].rem <= an;
        r_st[0].quo <= '0;
        r_st[0].div <= ad;
        r_st[0].neg <= i_num[32] ^ i_den[15];
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QBITS; k++) begin : g_bit
        localparam int SH = QBITS - 1 - k;
        always_ff @(posedge i_clk) begin
            logic [QBITS+16:0] rem_hi;
            logic [QBITS+16:0] dsh;
            rem_hi = {17'b0, r_st[k].rem};
            dsh = {{(QBITS+1){1'b0}}, r_st[k].div} << SH;
            r_st[k+1].div <= r_st[k].div;
            r_st[k+1].neg <= r_st[k].neg;
            if (rem_hi >= dsh) begin
                r_st[k+1].rem <= QBITS'(rem_hi - dsh);
                r_st[k+1].quo <= r_st[k].quo | (QBITS'(1) << SH);
            end else begin
                r_st[k+1].rem <= r_st[k].rem;
                r_st[k+1].quo <= r_st[k].quo;
            end
        end
    end

    assign w_q = r_st[QBITS].neg ? -$signed({1'b0, r_st[QBITS].quo})
                                 : $signed({1'b0, r_st[QBITS].quo});

    always_ff @(posedge i_clk) begin
        o_t <= sat32(w_q);
    end

endmodule

FILE: rtl/ray_box_slab_intersect.sv
// ray versus box slab test, one ray item per cycle, busy is never high. the result
// strobe follows the item through the restoring dividers: an operand register at
// the accepting edge, one quotient bit per stage (47 stages), then saturate, reduce
// and output registers. the result strobe lasts one cycle and cannot be held off by
// the receiver.
module ray_box_slab_intersect
    import rbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_org_x,
    input  logic signed [31:0] i_org_y,
    input  logic signed [31:0] i_org_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_distance
);

    localparam int LAT = QBITS + 2;

    logic signed [31:0] r_box [6];
    logic [2:0]         w_idx;
    logic signed [31:0] w_org [AXES];
    logic signed [15:0] w_dir [AXES];
    logic signed [31:0] w_t   [AXES][2];
    t_axis              r_ax  [LAT][AXES];
    logic [LAT-1:0]     r_vld;
    logic signed [31:0] r_entry;
    logic signed [31:0] r_exit;
    logic               r_red_vld;
    logic               r_valid;
    logic               r_hit;
    logic signed [31:0] r_dist;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_box[i] <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_MIN_X, REG_MIN_Y, REG_MIN_Z,
                REG_MAX_X, REG_MAX_Y, REG_MAX_Z: r_box[w_idx] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MIN_X, REG_MIN_Y, REG_MIN_Z,
            REG_MAX_X, REG_MAX_Y, REG_MAX_Z: prdata = r_box[w_idx];
            default: prdata = '0;
        endcase
    end

    assign w_org[0] = i_org_x;
    assign w_org[1] = i_org_y;
    assign w_org[2] = i_org_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        for (genvar s = 0; s < 2; s++) begin : g_side
            rbs_div_pipe u_div (
                .i_clk (i_clk),
                .i_num (33'(r_box[a + 3*s]) - 33'(w_org[a])),
                .i_den (w_dir[a] == 16'sd0 ? 16'sd1 : w_dir[a]),
                .o_t   (w_t[a][s])
            );
        end
        always_ff @(posedge i_clk) begin
            r_ax[0][a].zero    <= (w_dir[a] == 16'sd0);
            r_ax[0][a].in_slab <= (r_box[a] <= w_org[a]) && (w_org[a] <= r_box[a+3]);
            for (int k = 1; k < LAT; k++) r_ax[k][a] <= r_ax[k-1][a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_red_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_vld     <= {r_vld[LAT-2:0], start};
            r_red_vld <= r_vld[LAT-1];
            r_valid   <= r_red_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] en, ex, nr, fr;
        en = T_MIN;
        ex = T_MAX;
        for (int a = 0; a < AXES; a++) begin
            if (r_ax[LAT-1][a].zero) begin
                nr = r_ax[LAT-1][a].in_slab ? T_MIN : T_MAX;
                fr = r_ax[LAT-1][a].in_slab ? T_MAX : T_MIN;
            end else begin
                nr = (w_t[a][0] < w_t[a][1]) ? w_t[a][0] : w_t[a][1];
                fr = (w_t[a][0] < w_t[a][1]) ? w_t[a][1] : w_t[a][0];
            end
            if (nr > en) en = nr;
            if (fr < ex) ex = fr;
        end
        r_entry <= en;
        r_exit  <= ex;
    end

    always_ff @(posedge i_clk) begin
        if (r_exit < 0 || r_entry > r_exit) begin
            r_hit  <= 1'b0;
            r_dist <= r_exit;
        end else begin
            r_hit  <= 1'b1;
            r_dist <= r_entry;
        end
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

endmodule

FILE: rtl/rbs_checker.sv
`include "ray_box_slab_intersect_macros.svh"
module rbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               pready,
    input logic               o_valid,
    input logic               o_hit,
    input logic signed [31:0] o_distance
);
    `RBS_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `RBS_ASSERT_IMPL(a_ready, i_clk, i_rst_n, 1'b1, pready)
    `RBS_ASSERT_NEXT(a_start_gives_valid, i_clk, i_rst_n, start && !busy, ##50 o_valid)
    `RBS_ASSERT_IMPL(a_valid_had_start, i_clk, i_rst_n, o_valid, $past(start && !busy, 51))
    `RBS_ASSERT_IMPL(a_known, i_clk, i_rst_n, o_valid, !$isunknown(o_hit) && !$isunknown(o_distance))
endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .pready     (pready),
    .o_valid    (o_valid),
    .o_hit      (o_hit),
    .o_distance (o_distance)
);
